### sv/mtg_pkg.sv
// mtg_pkg: shared constants and word functions for the MT19937 generator.
// Used by every module in sv/; depends on nothing.
package mtg_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 624;
    localparam int unsigned FAR_OFFSET      = 397;
    localparam int unsigned WORD_W          = 32;

    localparam logic [31:0] SEED_MULT = 32'h6c07_8965;
    localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT  = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS  = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

    // Command codes
    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_RESEED   = 1'b1;

    // Status of the seeding sequencer toward the cell chain
    typedef struct packed {
        logic        busy;
        logic        shift;
        logic [31:0] word;
    } seed_stat_t;

    // Twist of one word from the words at position, position+1, position+397
    function automatic logic [31:0] twist(
        input logic [31:0] here,
        input logic [31:0] next,
        input logic [31:0] far
    );
        logic [31:0] y;
        y = (here & HIGH_BIT) | (next & LOW_BITS);
        return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
    endfunction

    // Output tempering
    function automatic logic [31:0] temper(input logic [31:0] w_in);
        logic [31:0] w;
        w = w_in;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & TEMPER_B);
        w = w ^ ((w << 15) & TEMPER_C);
        w = w ^ (w >> 18);
        return w;
    endfunction

endpackage

### sv/mtg_cell.sv
// mtg_cell: one word of the twist table in the shifting cell chain.
// Depends on mtg_pkg.
module mtg_cell (
    input  logic                         clk,
    input  logic                         shift,
    input  logic [mtg_pkg::WORD_W-1:0]   d,
    output logic [mtg_pkg::WORD_W-1:0]   q
);

    logic [mtg_pkg::WORD_W-1:0] word_reg;
    logic [mtg_pkg::WORD_W-1:0] word_next;

    // Take the neighbor's word on a shift, hold otherwise
    always_comb
    begin
        word_next = shift ? d : word_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

### sv/mtg_seed_unit.sv
// mtg_seed_unit: sequencer that streams the seeded table words into the chain.
// Depends on mtg_pkg; one 32x32 multiply per cycle, registered.
module mtg_seed_unit #(
    parameter int unsigned TABLE_DEPTH = mtg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         seed_value,
    output mtg_pkg::seed_stat_t stat
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [31:0]      word_reg;
    logic [31:0]      word_next;
    logic [31:0]      mix;
    logic [31:0]      prod;

    // Recurrence: w[i] = M * (w[i-1] ^ (w[i-1] >> 30)) + i, low 32 bits only
    always_comb
    begin
        mix  = word_reg ^ (word_reg >> 30);
        prod = mix * mtg_pkg::SEED_MULT;
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        word_next = word_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            word_next = seed_value;
        end
        else if (busy_reg)
        begin
            word_next = prod + 32'(idx_reg) + 32'd1;
            idx_next  = idx_reg + 1'b1;
            if (idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign stat.busy  = busy_reg;
    assign stat.shift = busy_reg;
    assign stat.word  = word_reg;

endmodule

### sv/mtg_out_buf.sv
// mtg_out_buf: two-entry output register with skid stage for result items.
// Depends on mtg_pkg.
module mtg_out_buf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [mtg_pkg::WORD_W-1:0] push_word,
    output logic                       full,
    output logic                       rnd_valid,
    input  logic                       rnd_ready,
    output logic [mtg_pkg::WORD_W-1:0] random_word
);

    logic                       head_valid_reg;
    logic                       head_valid_next;
    logic [mtg_pkg::WORD_W-1:0] head_reg;
    logic [mtg_pkg::WORD_W-1:0] head_next;
    logic                       skid_valid_reg;
    logic                       skid_valid_next;
    logic [mtg_pkg::WORD_W-1:0] skid_reg;
    logic [mtg_pkg::WORD_W-1:0] skid_next;

    // Pop first, then place a new item in the first free slot
    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (head_valid_reg && rnd_ready)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!head_valid_next)
            begin
                head_next       = push_word;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_word;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign full        = skid_valid_reg;
    assign rnd_valid   = head_valid_reg;
    assign random_word = head_reg;

endmodule

### sv/mersenne_twister_generator.sv
// mersenne_twister_generator: MT19937 with the table held as a chain of word cells.
// Generate: one item per cycle unless reseeding or the output buffer is full;
// its tempered word goes into that buffer. Reseed: TABLE_DEPTH (624) seeded words
// fill the chain, one multiply per cycle, with cmd_ready low. Reset clears handshake
// and sequencer state only; the table is undefined until the first reseed.
// Depends on mtg_pkg, mtg_cell, mtg_seed_unit, mtg_out_buf.
module mersenne_twister_generator #(
    parameter int unsigned TABLE_DEPTH = mtg_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic        command,
    input  logic [31:0] seed_value,
    output logic        rnd_valid,
    input  logic        rnd_ready,
    output logic [31:0] random_word
);

    mtg_pkg::seed_stat_t seed_stat;
    logic                buf_full;
    logic                accept;
    logic                gen_accept;
    logic                seed_start;
    logic                shift;
    logic [31:0]         tail_word;
    logic [31:0]         twisted;
    logic [31:0]         cell_q [TABLE_DEPTH];

    // Handshake and command decode
    assign cmd_ready  = !seed_stat.busy && !buf_full;
    assign accept     = cmd_valid && cmd_ready;
    assign gen_accept = accept && (command == mtg_pkg::CMD_GENERATE);
    assign seed_start = accept && (command == mtg_pkg::CMD_RESEED);

    // Cell 0 always holds the word at the current position
    assign twisted   = mtg_pkg::twist(cell_q[0], cell_q[1], cell_q[mtg_pkg::FAR_OFFSET]);
    assign shift     = gen_accept || seed_stat.shift;
    assign tail_word = seed_stat.busy ? seed_stat.word : twisted;

    // Chain of word cells; the new word enters at the tail
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            mtg_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (tail_word),
                .q     (cell_q[i])
            );
        end
        else
        begin : g_body
            mtg_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (cell_q[i+1]),
                .q     (cell_q[i])
            );
        end
    end

    mtg_seed_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seed (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (seed_start),
        .seed_value (seed_value),
        .stat       (seed_stat)
    );

    mtg_out_buf u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (gen_accept),
        .push_word   (mtg_pkg::temper(twisted)),
        .full        (buf_full),
        .rnd_valid   (rnd_valid),
        .rnd_ready   (rnd_ready),
        .random_word (random_word)
    );

endmodule

### test/mersenne_twister_generator_tb.sv
// Self-checking testbench for mersenne_twister_generator (MT19937, one word per generate).
// Holds a scoreboard class with its own table model; uses mtg_pkg for command codes
// and the generator constants. Needs only the RTL in sv/.
`timescale 1ns / 100ps

// Tracks the generator table and position and keeps the words the block should emit
class mt_scoreboard;
    localparam int unsigned DEPTH = mtg_pkg::TABLE_DEPTH_DEF;

    logic [31:0]  state_words [DEPTH];
    int unsigned  pos;
    logic [31:0]  pending_words [$];
    int unsigned  errors;
    int unsigned  words_checked;
    int unsigned  reseeds;
    int unsigned  wraps;

    function new();
        pos           = 0;
        errors        = 0;
        words_checked = 0;
        reseeds       = 0;
        wraps         = 0;
    endfunction

    // Update the table for one accepted item; a generate queues its tempered word
    function void note_item(input logic cmd, input logic [31:0] seed);
        logic [31:0] mix;
        logic [31:0] y;
        logic [31:0] t;
        int unsigned nxt;
        int unsigned far_idx;
        if (cmd == mtg_pkg::CMD_RESEED)
        begin
            state_words[0] = seed;
            for (int i = 1; i < DEPTH; i++)
            begin
                mix = state_words[i-1] ^ (state_words[i-1] >> 30);
                state_words[i] = mix * mtg_pkg::SEED_MULT + 32'(i);
            end
            pos = 0;
            reseeds++;
        end
        else
        begin
            nxt     = (pos + 1) % DEPTH;
            far_idx = (pos + mtg_pkg::FAR_OFFSET) % DEPTH;
            y = (state_words[pos] & mtg_pkg::HIGH_BIT) | (state_words[nxt] & mtg_pkg::LOW_BITS);
            t = state_words[far_idx] ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_XOR : 32'h0);
            state_words[pos] = t;
            if (nxt == 0)
                wraps++;
            pos = nxt;
            // tempering
            t = t ^ (t >> 11);
            t = t ^ ((t << 7) & mtg_pkg::TEMPER_B);
            t = t ^ ((t << 15) & mtg_pkg::TEMPER_C);
            t = t ^ (t >> 18);
            pending_words.push_back(t);
        end
    endfunction

    // Compare one emitted word with the oldest pending one
    function void check_word(input logic [31:0] actual);
        logic [31:0] want;
        if (pending_words.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected random_word: expected none, got %h", $time, actual);
        end
        else
        begin
            want = pending_words.pop_front();
            words_checked++;
            if (actual !== want)
            begin
                errors++;
                $display("%0t: random_word mismatch: expected %h, got %h",
                         $time, want, actual);
            end
        end
    endfunction
endclass

module mersenne_twister_generator_tb;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    logic        command;
    logic [31:0] seed_value;
    logic        rnd_valid;
    logic        rnd_ready;
    logic [31:0] random_word;

    int unsigned  sender_idle_pct;
    int unsigned  receiver_stall_pct;
    int unsigned  items_sent;
    mt_scoreboard sb;

    mersenne_twister_generator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command     (command),
        .seed_value  (seed_value),
        .rnd_valid   (rnd_valid),
        .rnd_ready   (rnd_ready),
        .random_word (random_word)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Known values on every input from time zero
    initial
    begin
        rst_n              = 1'b0;
        cmd_valid          = 1'b0;
        command            = mtg_pkg::CMD_GENERATE;
        seed_value         = 32'h0;
        rnd_ready          = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        items_sent         = 0;
        sb                 = new();
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
            rnd_ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    // Handshake monitor: note accepted items first, then check emitted words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                sb.note_item(command, seed_value);
            if (rnd_valid && rnd_ready)
                sb.check_word(random_word);
        end
    end

    // Present one item from a falling edge and hold it until accepted
    task automatic send_item(input logic cmd, input logic [31:0] seed);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid  = 1'b1;
        command    = cmd;
        seed_value = seed;
        do
            @(posedge clk);
        while (!cmd_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Reseed followed by a run of generates, repeated until the item goal is met.
    // A run of zero gives back-to-back reseeds; the optional long run wraps the position.
    task automatic run_stream(input int unsigned item_goal, input bit with_wrap);
        int unsigned start_count;
        int unsigned run_len;
        logic [31:0] seed;
        bit          long_done;
        start_count = items_sent;
        long_done   = !with_wrap;
        while (items_sent - start_count < item_goal)
        begin
            if ($urandom_range(9) == 0)
                seed = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
            else
                seed = $urandom();
            send_item(mtg_pkg::CMD_RESEED, seed);
            if (!long_done)
            begin
                run_len   = $urandom_range(700, 625);
                long_done = 1'b1;
            end
            else if ($urandom_range(7) == 0)
                run_len = 0;
            else
                run_len = $urandom_range(60, 1);
            for (int k = 0; k < run_len; k++)
                send_item(mtg_pkg::CMD_GENERATE, $urandom());
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: seed extremes, seed ignored on generate, back-to-back reseeds
        send_item(mtg_pkg::CMD_RESEED, 32'h0);
        send_item(mtg_pkg::CMD_GENERATE, 32'h0);
        send_item(mtg_pkg::CMD_GENERATE, 32'hffff_ffff);
        send_item(mtg_pkg::CMD_GENERATE, 32'h5555_aaaa);
        send_item(mtg_pkg::CMD_RESEED, 32'hffff_ffff);
        send_item(mtg_pkg::CMD_GENERATE, 32'hffff_ffff);
        send_item(mtg_pkg::CMD_GENERATE, 32'h0);
        send_item(mtg_pkg::CMD_GENERATE, 32'haaaa_5555);
        send_item(mtg_pkg::CMD_RESEED, 32'd5489);
        send_item(mtg_pkg::CMD_RESEED, 32'd5489);
        for (int k = 0; k < 5; k++)
            send_item(mtg_pkg::CMD_GENERATE, 32'h0);
        send_item(mtg_pkg::CMD_RESEED, 32'h8000_0001);
        send_item(mtg_pkg::CMD_GENERATE, 32'h8000_0000);
        send_item(mtg_pkg::CMD_GENERATE, 32'h7fff_ffff);

        // Random: four pacing phases, the first one long enough to wrap the position
        sender_idle_pct = 0;  receiver_stall_pct = 0;
        run_stream(180, 1'b1);
        sender_idle_pct = 82; receiver_stall_pct = 0;
        run_stream(180, 1'b0);
        sender_idle_pct = 0;  receiver_stall_pct = 82;
        run_stream(180, 1'b0);
        sender_idle_pct = 37; receiver_stall_pct = 37;
        run_stream(180, 1'b0);

        // Drain, then allow for a trailing reseed fill
        cmd_valid = 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);

        if (sb.pending_words.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d words never emitted, first expected %h",
                     $time, sb.pending_words.size(), sb.pending_words[0]);
        end
        $display("Ran %0d items (%0d reseeds) under four pacing phases.",
                 items_sent, sb.reseeds);
        $display("Checked %0d words across %0d position wraps; %0d errors.",
                 sb.words_checked, sb.wraps, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
sv/mtg_pkg.sv
sv/mtg_cell.sv
sv/mtg_seed_unit.sv
sv/mtg_out_buf.sv
sv/mersenne_twister_generator.sv
test/mersenne_twister_generator_tb.sv
